>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// command and character codes, request, result and cursor control types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);

    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    localparam logic [7:0] CHAR_BACKSPACE = 8'd27;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] ATTR_RESET     = 8'd8;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t     cmd;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } request_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [7:0]          cell_char;
        logic [7:0]          cell_attr;
    } result_t;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] code;
    } cell_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_SET,
        CUR_BACK,
        CUR_NEWLINE,
        CUR_ADVANCE
    } cur_op_t;

    typedef struct packed {
        cur_op_t    op;
        logic [6:0] set_col;
        logic [4:0] set_row;
    } cursor_ctl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lin;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scroll;
    } cursor_stat_t;

endpackage : tcw_pkg
`default_nettype wire

>>> rtl/core/tcw_screen_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : tcw_screen_ram
`default_nettype wire

>>> rtl/core/tcw_cursor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor unit: keeps the linear position together with row and column,
// applies set, step back, newline and advance, and flags a scroll.
// ----------------------------------------------------------------------------
module tcw_cursor (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tcw_pkg::cursor_ctl_t  ctl,
    output tcw_pkg::cursor_stat_t      stat
);

    localparam int COLS   = tcw_pkg::COLUMNS;
    localparam int ROWS   = tcw_pkg::ROWS;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_HOME = ADDR_W'((ROWS - 1) * COLS);

    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scroll;
    logic [COL_W-1:0]  set_c;
    logic [ROW_W-1:0]  set_r;

    always_comb
    begin
        set_c = (32'(ctl.set_col) > COLS - 1) ? COL_LAST : COL_W'(ctl.set_col);
        set_r = (32'(ctl.set_row) > ROWS - 1) ? ROW_LAST : ROW_W'(ctl.set_row);
        lin_next = lin_reg;
        row_next = row_reg;
        col_next = col_reg;
        scroll   = 1'b0;
        unique case (ctl.op)
            tcw_pkg::CUR_SET:
            begin
                row_next = set_r;
                col_next = set_c;
                lin_next = ADDR_W'(32'(set_r) * COLS + 32'(set_c));
            end
            tcw_pkg::CUR_BACK:
            begin
                if (lin_reg != '0)
                begin
                    lin_next = lin_reg - ADDR_W'(1);
                    if (col_reg == '0)
                    begin
                        col_next = COL_LAST;
                        row_next = row_reg - ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg - COL_W'(1);
                    end
                end
            end
            tcw_pkg::CUR_NEWLINE:
            begin
                col_next = '0;
                if (row_reg == ROW_LAST)
                begin
                    scroll   = 1'b1;
                    lin_next = LAST_HOME;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    lin_next = lin_reg + ADDR_W'(COLS) - ADDR_W'(col_reg);
                end
            end
            tcw_pkg::CUR_ADVANCE:
            begin
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    if (row_reg == ROW_LAST)
                    begin
                        scroll   = 1'b1;
                        lin_next = LAST_HOME;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                        lin_next = lin_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    lin_next = lin_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                lin_next = lin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            lin_reg <= lin_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign stat.lin    = lin_reg;
    assign stat.row    = row_reg;
    assign stat.col    = col_reg;
    assign stat.scroll = scroll;

endmodule : tcw_cursor
`default_nettype wire

>>> rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen store of character/attribute cells with a cursor. A set cursor
// is answered in the cycle after accept; a put runs S_BLANK, a read S_READ,
// a put with scroll then S_COPY and S_ZERO (one screen RAM port pair walks
// the store), clear screen S_SWEEP. busy is high while an item runs. After
// reset the RAM is cleared in a pass over all CELL_COUNT cells (2000 at
// 80x25) with busy high. Results last one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tcw_pkg::request_t  request,
    output logic                    result_valid,
    output tcw_pkg::result_t        result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    localparam int COLS   = tcw_pkg::COLUMNS;
    localparam int ROWS   = tcw_pkg::ROWS;
    localparam int CELLS  = tcw_pkg::CELL_COUNT;
    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CNT_W  = tcw_pkg::CNT_W;

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_SHIFT = CNT_W'(CELLS - COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLANK,
        S_READ,
        S_SWEEP,
        S_COPY,
        S_ZERO
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   pend_reg;
    logic                   scroll_reg;
    logic                   blank_ok_reg;
    logic [ADDR_W-1:0]      blank_addr_reg;
    logic                   hit_reg;
    tcw_pkg::cell_t         cell_reg;
    logic                   result_valid_reg;
    logic [7:0]             attr_reg;

    tcw_pkg::cursor_ctl_t   cur_ctl;
    tcw_pkg::cursor_stat_t  cur_stat;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    tcw_pkg::cell_t         ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [15:0]            ram_rdata;

    logic                   accept;
    logic                   is_back;
    logic                   is_newline;
    logic                   read_hit;
    logic [ADDR_W-1:0]      read_addr;
    logic [ADDR_W:0]        blank_at;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign is_back    = (request.char_code == tcw_pkg::CHAR_BACKSPACE);
    assign is_newline = (request.char_code == tcw_pkg::CHAR_NEWLINE);
    assign read_hit   = (32'(request.column) < COLS) && (32'(request.row) < ROWS);
    assign read_addr  = ADDR_W'(32'(request.row) * COLS + 32'(request.column));
    assign blank_at   = is_back ? {1'b0, cur_stat.lin}
                                : ({1'b0, cur_stat.lin} + (ADDR_W + 1)'(1));

    always_comb
    begin
        cur_ctl.op      = tcw_pkg::CUR_HOLD;
        cur_ctl.set_col = request.column;
        cur_ctl.set_row = request.row;
        if (accept)
        begin
            unique case (request.cmd)
                tcw_pkg::CMD_PUT:
                begin
                    priority if (is_back)
                        cur_ctl.op = tcw_pkg::CUR_BACK;
                    else if (is_newline)
                        cur_ctl.op = tcw_pkg::CUR_NEWLINE;
                    else
                        cur_ctl.op = tcw_pkg::CUR_ADVANCE;
                end
                tcw_pkg::CMD_SET:
                begin
                    cur_ctl.op = tcw_pkg::CUR_SET;
                end
                default:
                begin
                    cur_ctl.op = tcw_pkg::CUR_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = '0;
        ram_raddr      = read_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && request.cmd == tcw_pkg::CMD_PUT)
                begin
                    ram_wdata.attr = attr_reg;
                    priority if (is_back)
                    begin
                        ram_we    = (cur_stat.lin != '0);
                        ram_waddr = cur_stat.lin - ADDR_W'(1);
                    end
                    else if (is_newline)
                    begin
                        ram_we = 1'b0;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = cur_stat.lin;
                        ram_wdata.code = request.char_code;
                    end
                end
            end
            S_BLANK:
            begin
                ram_we         = blank_ok_reg;
                ram_waddr      = blank_addr_reg;
                ram_wdata.attr = attr_reg;
                ram_wdata.code = tcw_pkg::CHAR_SPACE;
            end
            S_COPY:
            begin
                ram_raddr = ADDR_W'(cnt_reg + CNT_W'(COLS));
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                ram_wdata = tcw_pkg::cell_t'(ram_rdata);
            end
            S_SWEEP, S_ZERO:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            scroll_reg       <= 1'b0;
            blank_ok_reg     <= 1'b0;
            blank_addr_reg   <= '0;
            hit_reg          <= 1'b0;
            cell_reg         <= '0;
            result_valid_reg <= 1'b0;
            attr_reg         <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    result_valid_reg <= accept && (request.cmd == tcw_pkg::CMD_SET);
                    if (accept)
                    begin
                        unique case (request.cmd)
                            tcw_pkg::CMD_PUT:
                            begin
                                state_reg      <= S_BLANK;
                                scroll_reg     <= cur_stat.scroll;
                                blank_ok_reg   <= (32'(blank_at) < CELLS);
                                blank_addr_reg <= blank_at[ADDR_W-1:0];
                            end
                            tcw_pkg::CMD_SET:
                            begin
                                cell_reg <= '0;
                            end
                            tcw_pkg::CMD_CLEAR:
                            begin
                                state_reg <= S_SWEEP;
                                cnt_reg   <= '0;
                                pend_reg  <= 1'b1;
                            end
                            default:
                            begin
                                state_reg <= S_READ;
                                hit_reg   <= read_hit;
                            end
                        endcase
                    end
                end
                S_BLANK:
                begin
                    result_valid_reg <= !scroll_reg;
                    if (scroll_reg)
                    begin
                        state_reg <= S_COPY;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        cell_reg  <= '0;
                    end
                end
                S_READ:
                begin
                    state_reg        <= S_IDLE;
                    result_valid_reg <= 1'b1;
                    cell_reg         <= hit_reg ? tcw_pkg::cell_t'(ram_rdata) : '0;
                end
                S_SWEEP:
                begin
                    result_valid_reg <= pend_reg && (cnt_reg == CNT_LAST);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_IDLE;
                        cell_reg  <= '0;
                        pend_reg  <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_COPY:
                begin
                    result_valid_reg <= 1'b0;
                    if (cnt_reg == CNT_SHIFT)
                    begin
                        state_reg <= S_ZERO;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_ZERO:
                begin
                    result_valid_reg <= (cnt_reg == CNT_LAST);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_IDLE;
                        cell_reg  <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    result_valid_reg <= 1'b0;
                    state_reg        <= S_IDLE;
                end
            endcase
        end
    end

    tcw_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cur_ctl),
        .stat  (cur_stat)
    );

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .WIDTH  (tcw_pkg::CELL_W),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_valid      = result_valid_reg;
    assign result.cursor_pos = tcw_pkg::CURSOR_W'(cur_stat.lin);
    assign result.cell_char  = cell_reg.code;
    assign result.cell_attr  = cell_reg.attr;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_stat.lin) < CELLS)
        else $error("cursor left the screen");

    a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_stat.lin) == 32'(cur_stat.row) * COLS + 32'(cur_stat.col))
        else $error("cursor position disagrees with row and column");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid))
        else $error("accepted transaction neither running nor answered");

    a_scroll_on_put_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> $past(state_reg == S_BLANK || state_reg == S_COPY))
        else $error("scroll started outside a put");

endmodule : text_console_writer
`default_nettype wire

>>> tb/sv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A directed table walks
// the screen corners, backspace at the first cell, newline, the dropped
// blank, scrolling, saturated cursor sets, out-of-range reads and clear.
// Random phases under several attribute settings then mix puts, cursor sets,
// reads and clears. Results are held to typed rows or a shadow screen model.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    typedef struct {
        tcw_pkg::request_t rq;
        bit                typed;
        tcw_pkg::result_t  res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    tcw_pkg::request_t  request;
    logic               result_valid;
    tcw_pkg::result_t   result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_data;

    tcw_pkg::cell_t     screen_shadow [tcw_pkg::CELL_COUNT];
    int                 cursor_shadow;
    logic [7:0]         attr_shadow;
    tcw_pkg::result_t   pending_results [$];
    int                 failures;

    text_console_writer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic tcw_pkg::request_t mk(tcw_pkg::cmd_e_t c, logic [7:0] ch,
                                             logic [6:0] col, logic [4:0] row_i);
        tcw_pkg::request_t rq;
        rq.cmd       = c;
        rq.char_code = ch;
        rq.column    = col;
        rq.row       = row_i;
        return rq;
    endfunction

    function automatic stim_row_t typed_row(tcw_pkg::request_t rq, int cur, int ch,
                                            int at);
        stim_row_t r;
        r.rq             = rq;
        r.typed          = 1'b1;
        r.res.cursor_pos = cur[tcw_pkg::CURSOR_W-1:0];
        r.res.cell_char  = ch[7:0];
        r.res.cell_attr  = at[7:0];
        return r;
    endfunction

    function automatic stim_row_t pred_row(tcw_pkg::request_t rq);
        stim_row_t r;
        r.rq    = rq;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    task automatic console_step(input tcw_pkg::request_t rq,
                                output tcw_pkg::result_t rs);
        int old;
        int blank_at;
        int col;
        int row_i;
        rs = '0;
        case (rq.cmd)
            tcw_pkg::CMD_PUT:
            begin
                old = cursor_shadow;
                if (rq.char_code == tcw_pkg::CHAR_BACKSPACE)
                begin
                    if (old > 0)
                    begin
                        screen_shadow[old-1] = {attr_shadow, 8'd0};
                        cursor_shadow = old - 1;
                    end
                    blank_at = old;
                end
                else if (rq.char_code == tcw_pkg::CHAR_NEWLINE)
                begin
                    cursor_shadow = old + (tcw_pkg::COLUMNS - old % tcw_pkg::COLUMNS);
                    blank_at = old + 1;
                end
                else
                begin
                    screen_shadow[old] = {attr_shadow, rq.char_code};
                    cursor_shadow = old + 1;
                    blank_at = old + 1;
                end
                if (blank_at < tcw_pkg::CELL_COUNT)
                    screen_shadow[blank_at] = {attr_shadow, tcw_pkg::CHAR_SPACE};
                if (cursor_shadow / tcw_pkg::COLUMNS > tcw_pkg::ROWS - 1)
                begin
                    for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
                        screen_shadow[i] = screen_shadow[i+tcw_pkg::COLUMNS];
                    for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;
                         i < tcw_pkg::CELL_COUNT; i++)
                        screen_shadow[i] = '0;
                    cursor_shadow = (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS;
                end
            end
            tcw_pkg::CMD_SET:
            begin
                col   = (rq.column > tcw_pkg::COLUMNS - 1) ? tcw_pkg::COLUMNS - 1
                                                           : int'(rq.column);
                row_i = (rq.row > tcw_pkg::ROWS - 1) ? tcw_pkg::ROWS - 1 : int'(rq.row);
                cursor_shadow = row_i * tcw_pkg::COLUMNS + col;
            end
            tcw_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
                    screen_shadow[i] = '0;
            end
            default:
            begin
                if (rq.column < tcw_pkg::COLUMNS && rq.row < tcw_pkg::ROWS)
                begin
                    rs.cell_char =
                        screen_shadow[rq.row * tcw_pkg::COLUMNS + rq.column].code;
                    rs.cell_attr =
                        screen_shadow[rq.row * tcw_pkg::COLUMNS + rq.column].attr;
                end
            end
        endcase
        rs.cursor_pos = cursor_shadow[tcw_pkg::CURSOR_W-1:0];
    endtask

    function automatic tcw_pkg::request_t random_request();
        tcw_pkg::request_t rq;
        int pick;
        int sel;
        int lin;
        rq.cmd       = tcw_pkg::CMD_PUT;
        rq.char_code = 8'($urandom_range(0, 255));
        rq.column    = 7'($urandom_range(0, 127));
        rq.row       = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if (sel < 12)
                rq.char_code = tcw_pkg::CHAR_NEWLINE;
            else if (sel < 20)
                rq.char_code = tcw_pkg::CHAR_BACKSPACE;
        end
        else if (pick < 70)
        begin
            rq.cmd = tcw_pkg::CMD_SET;
            if (sel < 85)
            begin
                rq.column = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
                rq.row    = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
            end
        end
        else if (pick < 98)
        begin
            rq.cmd = tcw_pkg::CMD_READ;
            if (sel < 50)
            begin
                lin = (cursor_shadow > 0) ? cursor_shadow - 1 : 0;
                rq.column = 7'(lin % tcw_pkg::COLUMNS);
                rq.row    = 5'(lin / tcw_pkg::COLUMNS);
            end
            else if (sel < 85)
            begin
                rq.column = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
                rq.row    = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
            end
        end
        else
            rq.cmd = tcw_pkg::CMD_CLEAR;
        return rq;
    endfunction

    task automatic send_request(input tcw_pkg::request_t rq, input bit typed,
                                input tcw_pkg::result_t typed_res, input bit allow_idle);
        tcw_pkg::result_t predicted;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        console_step(rq, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        attr_shadow = value;
    endtask

    always @(posedge clk)
    begin
        tcw_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result cursor_pos=%0d", result.cursor_pos);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.cursor_pos !== want.cursor_pos)
                begin
                    $error("cursor_pos expected %0d actual %0d", want.cursor_pos,
                           result.cursor_pos);
                    failures++;
                end
                if (result.cell_char !== want.cell_char)
                begin
                    $error("cell_char expected %0h actual %0h", want.cell_char,
                           result.cell_char);
                    failures++;
                end
                if (result.cell_attr !== want.cell_attr)
                begin
                    $error("cell_attr expected %0h actual %0h", want.cell_attr,
                           result.cell_attr);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t   directed_rows [$];
        logic [7:0]  phase_attr [4];
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        failures  = 0;
        cursor_shadow = 0;
        attr_shadow   = tcw_pkg::ATTR_RESET;
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
            screen_shadow[i] = '0;

        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0),
                                          0, 0, 0));
        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_SET, 8'hFF, 7'd127, 5'd31),
                                          1999, 0, 0));
        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd127, 5'd31),
                                          1999, 0, 0));
        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd24),
                                          1999, 0, 0));
        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_SET, 8'h00, 7'd0, 5'd0),
                                          0, 0, 0));
        directed_rows.push_back(typed_row(mk(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE,
                                             7'd0, 5'd0), 0, 0, 0));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, 8'h41, 7'd127, 5'd31)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE,
                                            7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE,
                                            7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd2, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_SET, 8'h00, 7'd79, 5'd24)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, 8'h5A, 7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd23)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd24)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_SET, 8'h00, 7'd79, 5'd24)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE,
                                            7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_SET, 8'h00, 7'd79, 5'd23)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE,
                                            7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd80, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd25)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_CLEAR, 8'h00, 7'd0, 5'd0)));
        directed_rows.push_back(pred_row(mk(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd23)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].typed,
                         directed_rows[i].res, 1'b1);
        start <= 1'b0;

        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 4; p++)
        begin
            write_attribute(phase_attr[p]);
            for (int n = 0; n < 270; n++)
                send_request(random_request(), 1'b0, '0, p < 3);
            start <= 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2100) @(posedge clk);
        if (failures == 0)
            $display("[text_console_writer] OK");
        else
            $display("[text_console_writer] ERROR");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("[text_console_writer] ERROR");
        $finish;
    end

endmodule

>>> text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_cursor.sv
rtl/core/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
